### hw/rtl/qdld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdld_pkg
// Shared types, codes and constants of the quadrature decoder with step
// lockout and pulse divider.
// ----------------------------------------------------------------------------
package qdld_pkg;

  // Default widths of the position count and the tick counter.
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned TICK_WIDTH_DEF  = 16;

  // Stream, configuration port and internal widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned LOCKOUT_W   = 16;
  localparam int unsigned DIVIDER_W   = 4;
  localparam int unsigned POS_OUT_W   = 32;
  localparam int unsigned ACCUM_W     = 5;

  // Register reset values.
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd2000;
  localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 4'd3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 1'd1;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_READ_DIR  = 2'd2
  } cmd_t;

  // Direction codes, two-bit two's complement.
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  // Position of each Gray phase (A,B) on the quadrature cycle.
  function automatic logic [1:0] cycle_pos(input logic [1:0] phase);
    logic [1:0] pos;
    case (phase)
      2'd0:    pos = 2'd2;
      2'd1:    pos = 2'd3;
      2'd2:    pos = 2'd1;
      default: pos = 2'd0;
    endcase
    return pos;
  endfunction

endpackage : qdld_pkg
`default_nettype wire

### hw/rtl/quadrature_decoder_lockout_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_decoder_lockout_divider
// Quadrature encoder decoder with a bounce lockout on raw steps and a
// pulse divider that turns same-direction raw pulses into count changes.
//
// Usage:
//   Every input beat is one tick: the encoder A/B levels and a command
//   (sample, clear count, read and clear direction). Each input beat gives
//   exactly one output beat with the signed position count, the latched
//   direction and a flag telling whether this sample changed the count.
//   A beat is registered on entry and processed by one stage of logic into
//   the output register, whose valid flag drives out_tvalid. One beat is
//   accepted every cycle while the output is drained. If the receiver stalls,
//   the input register still takes one more beat; then in_tready drops until
//   the output beat is taken.
//   Reset (synchronous, rst_n low) empties both registers, clears all
//   decoder state and loads the lockout (2000 ticks) and divider (3) reset
//   values. The first sample after reset only loads the phase.
//   Registers are written through cfg_we / cfg_index / cfg_wdata; the user
//   must write them only while the block is idle, the block has no check for it.
// ----------------------------------------------------------------------------
module quadrature_decoder_lockout_divider #(
  parameter int unsigned COUNT_WIDTH = qdld_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned TICK_WIDTH  = qdld_pkg::TICK_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Input beat: [1:0] command, [2] phase_a, [3] phase_b, rest zero
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [qdld_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Output beat: [31:0] position_count, [33:32] last_direction,
  // [34] count_changed, rest zero
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [qdld_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  wire                                  cfg_we,
  input  wire  [qdld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [qdld_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import qdld_pkg::*;

  localparam int unsigned CMP_W = (TICK_WIDTH > LOCKOUT_W) ? TICK_WIDTH : LOCKOUT_W;

  // Configuration registers.
  logic [LOCKOUT_W-1:0]   lockout_r;
  logic [DIVIDER_W-1:0]   divider_r;

  // Input register.
  logic                   s1_valid_r;
  logic [1:0]             s1_cmd_r;
  logic [1:0]             s1_phase_r;

  // Decoder state.
  logic [1:0]             prev_phase_r, prev_phase_nxt;
  logic                   loaded_r, loaded_nxt;
  logic [TICK_WIDTH-1:0]  ticks_r, ticks_nxt;
  logic [ACCUM_W-1:0]     accum_r, accum_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [1:0]             dir_r, dir_nxt;

  // Output register.
  logic                   out_valid_r;
  logic [POS_OUT_W-1:0]   out_pos_r;
  logic [1:0]             out_dir_r;
  logic                   out_chg_r;

  logic                   s1_advance;
  logic [1:0]             pos_delta;
  logic [TICK_WIDTH-1:0]  ticks_adv;
  logic                   step_ok;
  logic                   raw_up;
  logic                   accum_same;
  logic [ACCUM_W-1:0]     raw_val;
  logic [ACCUM_W-1:0]     accum_step;
  logic signed [ACCUM_W:0] accum_ext;
  logic signed [ACCUM_W:0] lim_pos;
  logic signed [ACCUM_W:0] lim_neg;
  logic                   chg;
  logic [1:0]             dir_out;
  logic [POS_OUT_W-1:0]   pos_out;

  assign s1_advance = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_advance;

  always_comb begin
    prev_phase_nxt = prev_phase_r;
    loaded_nxt     = loaded_r;
    accum_nxt      = accum_r;
    count_nxt      = count_r;
    dir_nxt        = dir_r;
    dir_out        = dir_r;
    chg            = 1'b0;

    // The tick counter saturates and advances on every beat; an accepted step clears it.
    ticks_adv = (ticks_r == {TICK_WIDTH{1'b1}}) ? ticks_r : ticks_r + 1'b1;
    ticks_nxt = ticks_adv;

    pos_delta = cycle_pos(s1_phase_r) - cycle_pos(prev_phase_r);
    raw_up    = (pos_delta == 2'd3);
    step_ok   = pos_delta[0] && (CMP_W'(ticks_adv) >= CMP_W'(lockout_r));

    raw_val    = raw_up ? ACCUM_W'(1) : {ACCUM_W{1'b1}};
    accum_same = (accum_r == '0) || (raw_up && !accum_r[ACCUM_W-1]) ||
                 (!raw_up && accum_r[ACCUM_W-1]);
    accum_step = accum_same ? accum_r + raw_val : raw_val;
    accum_ext  = $signed({accum_step[ACCUM_W-1], accum_step});
    lim_pos    = $signed({2'b00, divider_r});
    lim_neg    = -lim_pos;

    case (s1_cmd_r)
      CMD_SAMPLE: begin
        if (!loaded_r) begin
          loaded_nxt     = 1'b1;
          prev_phase_nxt = s1_phase_r;
        end else if (s1_phase_r != prev_phase_r) begin
          prev_phase_nxt = s1_phase_r;
          if (step_ok) begin
            ticks_nxt = '0;
            if (accum_ext >= lim_pos) begin
              count_nxt = count_r + 1'b1;
              dir_nxt   = DIR_POS;
              accum_nxt = '0;
              chg       = 1'b1;
            end else if (accum_ext <= lim_neg) begin
              count_nxt = count_r - 1'b1;
              dir_nxt   = DIR_NEG;
              accum_nxt = '0;
              chg       = 1'b1;
            end else begin
              accum_nxt = accum_step;
            end
          end
        end
        dir_out = dir_nxt;
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      CMD_READ_DIR: begin
        dir_nxt = DIR_NONE;
      end
      default: begin
      end
    endcase
  end

  // The reported position is the count sign-extended or truncated to 32 bits.
  generate
    if (COUNT_WIDTH >= POS_OUT_W) begin : g_pos_trunc
      assign pos_out = count_nxt[POS_OUT_W-1:0];
    end else begin : g_pos_sext
      assign pos_out = {{(POS_OUT_W-COUNT_WIDTH){count_nxt[COUNT_WIDTH-1]}}, count_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= LOCKOUT_RESET;
      divider_r <= DIVIDER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCKOUT: lockout_r <= cfg_wdata[LOCKOUT_W-1:0];
        REG_DIVIDER: divider_r <= cfg_wdata[DIVIDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r   <= in_tdata[1:0];
      s1_phase_r <= {in_tdata[2], in_tdata[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_phase_r <= '0;
      loaded_r     <= 1'b0;
      ticks_r      <= '0;
      accum_r      <= '0;
      count_r      <= '0;
      dir_r        <= DIR_NONE;
    end else if (s1_valid_r && s1_advance) begin
      prev_phase_r <= prev_phase_nxt;
      loaded_r     <= loaded_nxt;
      ticks_r      <= ticks_nxt;
      accum_r      <= accum_nxt;
      count_r      <= count_nxt;
      dir_r        <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_advance) begin
      out_pos_r <= pos_out;
      out_dir_r <= dir_out;
      out_chg_r <= chg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-POS_OUT_W-3){1'b0}}, out_chg_r, out_dir_r, out_pos_r};

endmodule : quadrature_decoder_lockout_divider
`default_nettype wire
